// ----- src/rsf_pkg.sv -----
// Shared types, widths and codes for the running-average film block.
package rsf_pkg;

	localparam int DOT_W  = 34;  // dot product of two Q2.14 vectors
	localparam int PROD_W = 68;  // product of two dot products
	localparam int UV_W   = 72;  // projected numerator and denominator
	localparam int DIV_W  = 88;  // divider working width
	localparam int QUO_W  = 16;  // divider quotient width
	localparam int RES_W  = 10;  // resolution register width
	localparam int COLQ_W = 16;  // quotient bits of a colour mean

	localparam logic [2:0] CFG_VIEW_AXIS   = 3'd0;
	localparam logic [2:0] CFG_FILM_X_AXIS = 3'd1;
	localparam logic [2:0] CFG_FILM_Y_AXIS = 3'd2;
	localparam logic [2:0] CFG_WIDTH       = 3'd3;
	localparam logic [2:0] CFG_HEIGHT      = 3'd4;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_SWEEP,
		ST_DOT,
		ST_MUL_AS,
		ST_MUL_SQ,
		ST_FORM,
		ST_CHECK,
		ST_SCALE,
		ST_DIVP_INIT,
		ST_DIV_PIX,
		ST_PIX,
		ST_READ,
		ST_MEAN_MUL,
		ST_MEAN_INIT,
		ST_DIV_COL,
		ST_MEAN_STORE,
		ST_WRITE,
		ST_MISS
	} state_t;

	typedef enum logic [1:0] {
		MUL_AS,
		MUL_SQ,
		MUL_MEAN
	} mul_sel_t;

	typedef struct packed {
		logic       in_load;
		logic       sweep_init;
		logic       sweep_wr;
		logic       dot_en;
		logic [2:0] dot_sel;
		logic       mul_en;
		mul_sel_t   mul_sel;
		logic       as_load;
		logic       form_en;
		logic       axis;
		logic       scale_init;
		logic       scale_step;
		logic       div_init_pix;
		logic       div_init_col;
		logic       div_step;
		logic       pix_store;
		logic       mem_rd;
		logic       mem_wr;
		logic       mean_store;
		logic [1:0] chan;
		logic       out_load;
		logic       out_hit;
	} dp_cmd_t;

	typedef struct packed {
		logic miss;
		logic sweep_last;
		logic out_busy;
	} dp_sts_t;

endpackage

// ----- src/rsf_ifs.sv -----
// Handshake channel interfaces: sample input, result output, register writes.
interface rsf_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic        [15:0] red;
	logic        [15:0] green;
	logic        [15:0] blue;
	logic signed [15:0] ray_x;
	logic signed [15:0] ray_y;
	logic signed [15:0] ray_z;
	modport source(output valid, kind, red, green, blue, ray_x, ray_y, ray_z, input ready);
	modport sink(input valid, kind, red, green, blue, ray_x, ray_y, ray_z, output ready);
endinterface

interface rsf_out_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [8:0]  pixel_col;
	logic [8:0]  pixel_row;
	logic [15:0] mean_red;
	logic [15:0] mean_green;
	logic [15:0] mean_blue;
	logic [15:0] samples_seen;
	modport source(output valid, hit, pixel_col, pixel_row, mean_red, mean_green, mean_blue,
		samples_seen, input ready);
	modport sink(input valid, hit, pixel_col, pixel_row, mean_red, mean_green, mean_blue,
		samples_seen, output ready);
endinterface

interface rsf_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [47:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- src/rsf_div.sv -----
// Shared restoring divider, one quotient bit per step, divisor pre-shifted.
module rsf_div (
	input  logic                      clk,
	input  logic                      init,
	input  logic                      step,
	input  logic [rsf_pkg::DIV_W-1:0] dividend,
	input  logic [rsf_pkg::DIV_W-1:0] divisor_sh,
	output logic [rsf_pkg::QUO_W-1:0] quo
);
	import rsf_pkg::*;

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] t_q;
	logic [QUO_W-1:0] quo_q;
	logic             ge;

	assign ge  = t_q <= rem_q;
	assign quo = quo_q;

	always_ff @(posedge clk) begin
		if (init) begin
			rem_q <= dividend;
			t_q   <= divisor_sh;
			quo_q <= '0;
		end else if (step) begin
			if (ge) begin
				rem_q <= rem_q - t_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			t_q   <= t_q >> 1;
		end
	end
endmodule

// ----- src/rsf_dp.sv -----
// Datapath: registers, dot unit, multiplier, projection, divider, pixel memory.
module rsf_dp #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rsf_pkg::dp_cmd_t    cmd,
	output rsf_pkg::dp_sts_t    sts,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [47:0]         cfg_data,
	input  logic [15:0]         in_red,
	input  logic [15:0]         in_green,
	input  logic [15:0]         in_blue,
	input  logic [15:0]         in_ray_x,
	input  logic [15:0]         in_ray_y,
	input  logic [15:0]         in_ray_z,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                out_hit,
	output logic [8:0]          out_col,
	output logic [8:0]          out_row,
	output logic [15:0]         out_red,
	output logic [15:0]         out_green,
	output logic [15:0]         out_blue,
	output logic [15:0]         out_seen
);
	import rsf_pkg::*;

	localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int EW     = 48 + COUNT_BITS;

	function automatic logic signed [DOT_W-1:0] dot3(input logic [47:0] p, input logic [47:0] r);
		logic signed [31:0] p0, p1, p2;
		p0 = $signed(p[15:0]) * $signed(r[15:0]);
		p1 = $signed(p[31:16]) * $signed(r[31:16]);
		p2 = $signed(p[47:32]) * $signed(r[47:32]);
		return DOT_W'(p0) + DOT_W'(p1) + DOT_W'(p2);
	endfunction

	// configuration
	logic [47:0]      view_q, xaxis_q, yaxis_q;
	logic [RES_W-1:0] wcfg_q, hcfg_q;
	logic [RES_W-1:0] res_w, res_h, res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_q  <= '0;
			xaxis_q <= '0;
			yaxis_q <= '0;
			wcfg_q  <= 10'd512;
			hcfg_q  <= 10'd512;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VIEW_AXIS:   view_q  <= cfg_data;
				CFG_FILM_X_AXIS: xaxis_q <= cfg_data;
				CFG_FILM_Y_AXIS: yaxis_q <= cfg_data;
				CFG_WIDTH:       wcfg_q  <= cfg_data[RES_W-1:0];
				CFG_HEIGHT:      hcfg_q  <= cfg_data[RES_W-1:0];
				default: ;
			endcase
		end
	end

	assign res_w = (32'(wcfg_q) < MAX_WIDTH) ? wcfg_q : RES_W'(MAX_WIDTH);
	assign res_h = (32'(hcfg_q) < MAX_HEIGHT) ? hcfg_q : RES_W'(MAX_HEIGHT);
	assign res   = cmd.axis ? res_h : res_w;

	// captured word; fill colour is cleared by reset for the power-up sweep
	logic [47:0] dir_q;
	logic [15:0] col_q [3];
	logic [47:0] fill_q;

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			dir_q    <= {in_ray_z, in_ray_y, in_ray_x};
			col_q[0] <= in_red;
			col_q[1] <= in_green;
			col_q[2] <= in_blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.in_load) begin
			fill_q <= {in_blue, in_green, in_red};
		end
	end

	// dot products: s, d.X, A.X, X.X, d.Y, A.Y, Y.Y
	logic signed [DOT_W-1:0] dot_q [7];
	logic [47:0]             dop_a, dop_b;

	always_comb begin
		case (cmd.dot_sel)
			3'd0:    begin dop_a = dir_q;   dop_b = view_q;  end
			3'd1:    begin dop_a = dir_q;   dop_b = xaxis_q; end
			3'd2:    begin dop_a = view_q;  dop_b = xaxis_q; end
			3'd3:    begin dop_a = xaxis_q; dop_b = xaxis_q; end
			3'd4:    begin dop_a = dir_q;   dop_b = yaxis_q; end
			3'd5:    begin dop_a = view_q;  dop_b = yaxis_q; end
			default: begin dop_a = yaxis_q; dop_b = yaxis_q; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.dot_en) begin
			dot_q[cmd.dot_sel] <= dot3(dop_a, dop_b);
		end
	end

	logic signed [DOT_W-1:0] dn, da, dq, ds;
	assign ds = dot_q[0];
	assign dn = cmd.axis ? dot_q[4] : dot_q[1];
	assign da = cmd.axis ? dot_q[5] : dot_q[2];
	assign dq = cmd.axis ? dot_q[6] : dot_q[3];

	// memory read word and running-mean terms
	logic [EW-1:0]         rd_q;
	logic [COUNT_BITS-1:0] cnt_old, m;
	logic [15:0]           old_c, col_c;

	assign cnt_old = rd_q[EW-1:48];
	assign m       = (&cnt_old) ? cnt_old : cnt_old + 1'b1;

	always_comb begin
		case (cmd.chan)
			2'd0:    begin old_c = rd_q[15:0];  col_c = col_q[0]; end
			2'd1:    begin old_c = rd_q[31:16]; col_c = col_q[1]; end
			default: begin old_c = rd_q[47:32]; col_c = col_q[2]; end
		endcase
	end

	// shared multiplier
	logic signed [DOT_W-1:0]  mop_a, mop_b;
	logic signed [PROD_W-1:0] prod_q, as_q;

	always_comb begin
		case (cmd.mul_sel)
			MUL_AS:  begin mop_a = da; mop_b = ds; end
			MUL_SQ:  begin mop_a = ds; mop_b = dq; end
			default: begin
				mop_a = $signed({18'b0, old_c});
				mop_b = $signed(DOT_W'(m - 1'b1));
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mop_a * mop_b;
		end
		if (cmd.as_load) begin
			as_q <= prod_q;
		end
	end

	// projection: u = n*2^28 - a*s + s*q, v = 2*s*q, sign-normalised
	logic signed [UV_W-1:0] n_e, as_e, d_e, u_s, v_s, u_n, v_n;
	logic [UV_W-1:0]        u_q, v_q;
	logic                   miss_q;

	always_comb begin
		n_e  = {{(UV_W-DOT_W){dn[DOT_W-1]}}, dn} <<< 28;
		as_e = {{(UV_W-PROD_W){as_q[PROD_W-1]}}, as_q};
		d_e  = {{(UV_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
		u_s  = n_e - as_e + d_e;
		v_s  = d_e <<< 1;
		u_n  = v_s[UV_W-1] ? -u_s : u_s;
		v_n  = v_s[UV_W-1] ? -v_s : v_s;
	end

	always_ff @(posedge clk) begin
		if (cmd.form_en) begin
			u_q    <= u_n;
			v_q    <= v_n;
			miss_q <= (res == '0) || (v_s == '0) || u_n[UV_W-1] || ($unsigned(u_n) >= $unsigned(v_n));
		end
	end

	// u*res by shift and add
	logic [DIV_W-1:0] sc_acc_q, sc_u_q;
	logic [RES_W-1:0] sc_w_q;

	always_ff @(posedge clk) begin
		if (cmd.scale_init) begin
			sc_acc_q <= '0;
			sc_u_q   <= DIV_W'(u_q);
			sc_w_q   <= res;
		end else if (cmd.scale_step) begin
			if (sc_w_q[0]) begin
				sc_acc_q <= sc_acc_q + sc_u_q;
			end
			sc_u_q <= sc_u_q << 1;
			sc_w_q <= sc_w_q >> 1;
		end
	end

	// divider operands
	logic [DIV_W-1:0] dvd, dvs;
	logic [QUO_W-1:0] quo;

	always_comb begin
		if (cmd.div_init_pix) begin
			dvd = sc_acc_q;
			dvs = DIV_W'(v_q) << (RES_W - 1);
		end else begin
			dvd = DIV_W'(prod_q[47:0]) + DIV_W'(col_c) + DIV_W'(m >> 1);
			dvs = DIV_W'(m) << (COLQ_W - 1);
		end
	end

	rsf_div u_div (
		.clk       (clk),
		.init      (cmd.div_init_pix | cmd.div_init_col),
		.step      (cmd.div_step),
		.dividend  (dvd),
		.divisor_sh(dvs),
		.quo       (quo)
	);

	logic [RES_W-1:0] px_q, py_q;
	logic [15:0]      mean_q [3];

	always_ff @(posedge clk) begin
		if (cmd.pix_store) begin
			if (cmd.axis) begin
				py_q <= quo[RES_W-1:0];
			end else begin
				px_q <= quo[RES_W-1:0];
			end
		end
		if (cmd.mean_store) begin
			case (cmd.chan)
				2'd0:    mean_q[0] <= quo;
				2'd1:    mean_q[1] <= quo;
				default: mean_q[2] <= quo;
			endcase
		end
	end

	// pixel memory: colour in the low 48 bits, count above
	logic [EW-1:0] mem_q [PIXELS];
	logic [AW-1:0] addr_w, sweep_q, wa;
	logic [EW-1:0] wd;

	assign addr_w = AW'(32'(py_q) * MAX_WIDTH + 32'(px_q));
	assign wa     = cmd.sweep_wr ? sweep_q : addr_w;
	assign wd     = cmd.sweep_wr ? {{COUNT_BITS{1'b0}}, fill_q}
	                             : {m, mean_q[2], mean_q[1], mean_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_init) begin
			sweep_q <= '0;
		end else if (cmd.sweep_wr) begin
			sweep_q <= sweep_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_wr || cmd.mem_wr) begin
			mem_q[wa] <= wd;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem_q[addr_w];
		end
	end

	// output register
	logic        out_valid_q, hit_q;
	logic [8:0]  col_oq, row_oq;
	logic [15:0] red_oq, green_oq, blue_oq, seen_oq;
	logic [31:0] m32;

	assign m32 = 32'(m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			hit_q    <= cmd.out_hit;
			col_oq   <= cmd.out_hit ? px_q[8:0] : '0;
			row_oq   <= cmd.out_hit ? py_q[8:0] : '0;
			red_oq   <= cmd.out_hit ? mean_q[0] : '0;
			green_oq <= cmd.out_hit ? mean_q[1] : '0;
			blue_oq  <= cmd.out_hit ? mean_q[2] : '0;
			seen_oq  <= !cmd.out_hit ? '0 : ((m32 > 32'hFFFF) ? 16'hFFFF : m32[15:0]);
		end
	end

	assign out_valid = out_valid_q;
	assign out_hit   = hit_q;
	assign out_col   = col_oq;
	assign out_row   = row_oq;
	assign out_red   = red_oq;
	assign out_green = green_oq;
	assign out_blue  = blue_oq;
	assign out_seen  = seen_oq;

	assign sts.miss       = miss_q;
	assign sts.sweep_last = sweep_q == AW'(PIXELS - 1);
	assign sts.out_busy   = out_valid_q & ~out_ready;
endmodule

// ----- src/rsf_ctrl.sv -----
// Sequencer: steps the datapath through projection, averaging and sweeps.
module rsf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_kind,
	output logic             in_ready,
	input  rsf_pkg::dp_sts_t sts,
	output rsf_pkg::dp_cmd_t cmd
);
	import rsf_pkg::*;

	state_t     state_q, state_d;
	logic [4:0] cnt_q;
	logic       axis_q;
	logic [1:0] chan_q;
	logic       fire;

	assign fire = in_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT:       if (sts.sweep_last) state_d = ST_IDLE;
			ST_IDLE:       if (fire) state_d = in_kind ? ST_SWEEP : ST_DOT;
			ST_SWEEP:      if (sts.sweep_last) state_d = ST_MISS;
			ST_DOT:        if (cnt_q == 5'd6) state_d = ST_MUL_AS;
			ST_MUL_AS:     state_d = ST_MUL_SQ;
			ST_MUL_SQ:     state_d = ST_FORM;
			ST_FORM:       state_d = ST_CHECK;
			ST_CHECK:      state_d = sts.miss ? ST_MISS : ST_SCALE;
			ST_SCALE:      if (cnt_q == 5'(RES_W - 1)) state_d = ST_DIVP_INIT;
			ST_DIVP_INIT:  state_d = ST_DIV_PIX;
			ST_DIV_PIX:    if (cnt_q == 5'(RES_W - 1)) state_d = ST_PIX;
			ST_PIX:        state_d = axis_q ? ST_READ : ST_MUL_AS;
			ST_READ:       state_d = ST_MEAN_MUL;
			ST_MEAN_MUL:   state_d = ST_MEAN_INIT;
			ST_MEAN_INIT:  state_d = ST_DIV_COL;
			ST_DIV_COL:    if (cnt_q == 5'(COLQ_W - 1)) state_d = ST_MEAN_STORE;
			ST_MEAN_STORE: state_d = (chan_q == 2'd2) ? ST_WRITE : ST_MEAN_MUL;
			ST_WRITE:      if (!sts.out_busy) state_d = ST_IDLE;
			ST_MISS:       if (!sts.out_busy) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.axis    = axis_q;
		cmd.chan    = chan_q;
		cmd.dot_sel = cnt_q[2:0];
		cmd.mul_sel = MUL_MEAN;
		in_ready    = 1'b0;
		case (state_q)
			ST_INIT:  cmd.sweep_wr = 1'b1;
			ST_IDLE: begin
				in_ready       = 1'b1;
				cmd.in_load    = fire;
				cmd.sweep_init = fire;
			end
			ST_SWEEP: cmd.sweep_wr = 1'b1;
			ST_DOT:   cmd.dot_en = 1'b1;
			ST_MUL_AS: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_AS;
			end
			ST_MUL_SQ: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SQ;
				cmd.as_load = 1'b1;
			end
			ST_FORM:       cmd.form_en = 1'b1;
			ST_CHECK:      cmd.scale_init = ~sts.miss;
			ST_SCALE:      cmd.scale_step = 1'b1;
			ST_DIVP_INIT:  cmd.div_init_pix = 1'b1;
			ST_DIV_PIX:    cmd.div_step = 1'b1;
			ST_PIX:        cmd.pix_store = 1'b1;
			ST_READ:       cmd.mem_rd = 1'b1;
			ST_MEAN_MUL:   cmd.mul_en = 1'b1;
			ST_MEAN_INIT:  cmd.div_init_col = 1'b1;
			ST_DIV_COL:    cmd.div_step = 1'b1;
			ST_MEAN_STORE: cmd.mean_store = 1'b1;
			ST_WRITE: begin
				cmd.mem_wr   = ~sts.out_busy;
				cmd.out_load = ~sts.out_busy;
				cmd.out_hit  = 1'b1;
			end
			ST_MISS:  cmd.out_load = ~sts.out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
			axis_q  <= 1'b0;
			chan_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? 5'd0 : cnt_q + 5'd1;
			if (state_q == ST_DOT) begin
				axis_q <= 1'b0;
			end else if (state_q == ST_PIX) begin
				axis_q <= 1'b1;
			end
			if (state_q == ST_READ) begin
				chan_q <= 2'd0;
			end else if (state_q == ST_MEAN_STORE) begin
				chan_q <= chan_q + 2'd1;
			end
		end
	end
endmodule

// ----- src/ray_splat_running_average_film.sv -----
// Running-average film: projects ray samples to pixels and keeps per-pixel means.
//
// Channels: sample (splat or clear word in), result (one word out per sample word),
// cfg (register writes, always ready; write only while the block is idle).
// A splat word projects its direction onto the film, reads the pixel, updates its
// colour to the running mean and its saturating count, and returns the pixel.
// A miss or a clear returns a word with hit low and every other field zero.
// Throughput: one sample word at a time. From acceptance to result a splat runs
// the 7 dot products, then per film axis the shared multiplier and the 10-step
// divider, then per colour channel the 16-step divider, plus the memory read
// and write. A clear sweeps the whole memory, one pixel per cycle through the
// single memory write port.
// After reset the block sweeps the memory to zero and takes no sample word
// meanwhile; register writes are taken throughout.
// The result register lets the next sample word in while a result waits; a
// stalled receiver holds the block only when the next result is ready.
module ray_splat_running_average_film #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int COUNT_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	rsf_cfg_if.sink    cfg,
	rsf_in_if.sink     sample,
	rsf_out_if.source  result
);
	import rsf_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg.ready = 1'b1;

	rsf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(sample.valid),
		.in_kind (sample.kind),
		.in_ready(sample.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	rsf_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg.valid),
		.cfg_index(cfg.index),
		.cfg_data (cfg.data),
		.in_red   (sample.red),
		.in_green (sample.green),
		.in_blue  (sample.blue),
		.in_ray_x (sample.ray_x),
		.in_ray_y (sample.ray_y),
		.in_ray_z (sample.ray_z),
		.out_ready(result.ready),
		.out_valid(result.valid),
		.out_hit  (result.hit),
		.out_col  (result.pixel_col),
		.out_row  (result.pixel_row),
		.out_red  (result.mean_red),
		.out_green(result.mean_green),
		.out_blue (result.mean_blue),
		.out_seen (result.samples_seen)
	);
endmodule

// ----- src/rsf_chk.sv -----
// Port-level checks for the running-average film, bound to the top level.
module rsf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        hit,
	input logic [8:0]  pixel_col,
	input logic [8:0]  pixel_row,
	input logic [15:0] mean_red,
	input logic [15:0] mean_green,
	input logic [15:0] mean_blue,
	input logic [15:0] samples_seen
);
	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(pixel_col)
		&& $stable(pixel_row) && $stable(samples_seen))
		else $error("stalled result changed");

	// one word in flight: ready drops after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while busy");

	// misses and clears carry an all-zero payload
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> pixel_col == 9'd0 && pixel_row == 9'd0 && mean_red == 16'd0
		&& mean_green == 16'd0 && mean_blue == 16'd0 && samples_seen == 16'd0)
		else $error("miss word with payload");

	// a hit always counts at least one sample
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> samples_seen != 16'd0)
		else $error("hit with zero count");
endmodule

bind ray_splat_running_average_film rsf_chk u_rsf_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sample.valid),
	.in_ready    (sample.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.hit         (result.hit),
	.pixel_col   (result.pixel_col),
	.pixel_row   (result.pixel_row),
	.mean_red    (result.mean_red),
	.mean_green  (result.mean_green),
	.mean_blue   (result.mean_blue),
	.samples_seen(result.samples_seen)
);

// ----- tb/tb_ifs_note.sv -----
`timescale 1ns / 100ps
// Shared types of the film testbench: sample word, result word, word kinds and the Q2.14 unit.
package tb_film_pkg;

	typedef struct {
		logic        kind;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] ray_x;
		logic [15:0] ray_y;
		logic [15:0] ray_z;
	} sample_word_t;

	typedef struct {
		logic        hit;
		logic [8:0]  pixel_col;
		logic [8:0]  pixel_row;
		logic [15:0] mean_red;
		logic [15:0] mean_green;
		logic [15:0] mean_blue;
		logic [15:0] samples_seen;
	} pixel_word_t;

	localparam logic KIND_SPLAT = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// Q2.14 unit
	localparam logic [15:0] Q_ONE = 16'h4000;

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top-level testbench of the running-average film: stimulus, pixel predictor, checker.
module tb_top;
	import rsf_pkg::*;
	import tb_film_pkg::*;

	localparam int FILM_W     = 512;
	localparam int FILM_H     = 512;
	localparam int COUNT_MAX  = 65535;
	localparam int IDLE_LIMIT = 1200000;
	localparam int DRAIN_GAP  = 300;

	logic clk;
	logic arst_n;

	rsf_cfg_if cfg_ch();
	rsf_in_if  in_ch();
	rsf_out_if out_ch();

	ray_splat_running_average_film u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.sample(in_ch),
		.result(out_ch)
	);

	// film state as the block should see it
	logic [47:0] view_axis_q, film_x_q, film_y_q;
	logic [9:0]  width_q, height_q;
	logic [47:0] fill_colour;
	logic [47:0] colour_store [int];
	int          count_store [int];

	pixel_word_t expected_pixels[$];
	int          fail_count;
	int          idle_cycles;
	bit          calm;
	int          hold_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data  = '0;
		in_ch.valid  = 1'b0;
		in_ch.kind   = 1'b0;
		in_ch.red    = '0;
		in_ch.green  = '0;
		in_ch.blue   = '0;
		in_ch.ray_x  = '0;
		in_ch.ray_y  = '0;
		in_ch.ray_z  = '0;
	end

	function automatic longint dot3(logic [47:0] p, logic [47:0] q);
		return longint'($signed(p[15:0])) * longint'($signed(q[15:0]))
			+ longint'($signed(p[31:16])) * longint'($signed(q[31:16]))
			+ longint'($signed(p[47:32])) * longint'($signed(q[47:32]));
	endfunction

	// pixel coordinate along one film axis, -1 on a miss
	function automatic int project_axis(logic [47:0] dir, logic [47:0] axis, int res);
		logic signed [127:0] bs, bn, ba, bq, br, u, v;
		bs = dot3(dir, view_axis_q);
		bn = dot3(dir, axis);
		ba = dot3(view_axis_q, axis);
		bq = dot3(axis, axis);
		br = res;
		u = (bn <<< 28) - ba * bs + bs * bq;
		v = 2 * bs * bq;
		if (res == 0 || v == 0)
			return -1;
		if (v < 0) begin
			u = -u;
			v = -v;
		end
		if (u < 0 || u >= v)
			return -1;
		return int'((u * br) / v);
	endfunction

	function automatic pixel_word_t film_mean_predict(sample_word_t s);
		pixel_word_t r;
		int w, h, px, py, idx, m;
		logic [47:0] old, upd, smp;
		longint acc;
		r = '{default: '0};
		if (s.kind == KIND_CLEAR) begin
			fill_colour = {s.blue, s.green, s.red};
			colour_store.delete();
			count_store.delete();
			return r;
		end
		w = (width_q < FILM_W) ? int'(width_q) : FILM_W;
		h = (height_q < FILM_H) ? int'(height_q) : FILM_H;
		px = project_axis({s.ray_z, s.ray_y, s.ray_x}, film_x_q, w);
		py = project_axis({s.ray_z, s.ray_y, s.ray_x}, film_y_q, h);
		if (px < 0 || py < 0 || px >= w || py >= h)
			return r;
		idx = px + FILM_W * py;
		old = colour_store.exists(idx) ? colour_store[idx] : fill_colour;
		m = (count_store.exists(idx) ? count_store[idx] : 0) + 1;
		if (m > COUNT_MAX)
			m = COUNT_MAX;
		smp = {s.blue, s.green, s.red};
		for (int k = 0; k < 3; k++) begin
			acc = longint'(old[16*k +: 16]) * (m - 1) + smp[16*k +: 16] + m / 2;
			upd[16*k +: 16] = 16'(acc / m);
		end
		colour_store[idx] = upd;
		count_store[idx]  = m;
		r.hit          = 1'b1;
		r.pixel_col    = 9'(px);
		r.pixel_row    = 9'(py);
		r.mean_red     = upd[15:0];
		r.mean_green   = upd[31:16];
		r.mean_blue    = upd[47:32];
		r.samples_seen = 16'(m);
		return r;
	endfunction

	// receiver: random stalls, long hold on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready = 1'b0;
			end else
				out_ch.ready = calm || ($urandom_range(99) >= 14);
		end
	end

	function automatic void check_field(string name, longint exp_v, longint got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			fail_count++;
		end
	endfunction

	initial begin
		pixel_word_t e;
		forever begin
			@(posedge clk);
			if (in_ch.valid && in_ch.ready || cfg_ch.valid && cfg_ch.ready)
				idle_cycles = 0;
			if (out_ch.valid && out_ch.ready) begin
				idle_cycles = 0;
				if (expected_pixels.size() == 0) begin
					$error("result word with nothing expected");
					fail_count++;
				end else begin
					e = expected_pixels.pop_front();
					check_field("hit", e.hit, out_ch.hit);
					check_field("pixel_col", e.pixel_col, out_ch.pixel_col);
					check_field("pixel_row", e.pixel_row, out_ch.pixel_row);
					check_field("mean_red", e.mean_red, out_ch.mean_red);
					check_field("mean_green", e.mean_green, out_ch.mean_green);
					check_field("mean_blue", e.mean_blue, out_ch.mean_blue);
					check_field("samples_seen", e.samples_seen, out_ch.samples_seen);
				end
			end else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic send_sample(sample_word_t s);
		@(negedge clk);
		if (!calm && $urandom_range(99) < 14) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_ch.kind  = s.kind;
		in_ch.red   = s.red;
		in_ch.green = s.green;
		in_ch.blue  = s.blue;
		in_ch.ray_x = s.ray_x;
		in_ch.ray_y = s.ray_y;
		in_ch.ray_z = s.ray_z;
		in_ch.valid = 1'b1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		expected_pixels.push_back(film_mean_predict(s));
	endtask

	task automatic drain_film;
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [47:0] value);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			CFG_VIEW_AXIS:   view_axis_q = value;
			CFG_FILM_X_AXIS: film_x_q = value;
			CFG_FILM_Y_AXIS: film_y_q = value;
			CFG_WIDTH:       width_q = value[9:0];
			CFG_HEIGHT:      height_q = value[9:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic set_film(logic [47:0] va, logic [47:0] xa, logic [47:0] ya,
			logic [9:0] w, logic [9:0] h);
		write_reg(CFG_VIEW_AXIS, va);
		write_reg(CFG_FILM_X_AXIS, xa);
		write_reg(CFG_FILM_Y_AXIS, ya);
		write_reg(CFG_WIDTH, 48'(w));
		write_reg(CFG_HEIGHT, 48'(h));
	endtask

	function automatic sample_word_t make_splat(logic [15:0] x, logic [15:0] y,
			logic [15:0] z, logic [15:0] r, logic [15:0] g, logic [15:0] b);
		sample_word_t s;
		s.kind = KIND_SPLAT;
		s.red = r; s.green = g; s.blue = b;
		s.ray_x = x; s.ray_y = y; s.ray_z = z;
		return s;
	endfunction

	// forward-looking ray for the square camera, with the odd raw word mixed in
	function automatic sample_word_t random_splat();
		logic [15:0] x, y, z;
		if ($urandom_range(99) < 80) begin
			x = 16'($urandom_range(32767) - 16384);
			y = 16'($urandom_range(32767) - 16384);
			z = Q_ONE;
		end else begin
			x = 16'($urandom);
			y = 16'($urandom);
			z = 16'($urandom);
		end
		return make_splat(x, y, z, 16'($urandom), 16'($urandom), 16'($urandom));
	endfunction

	task automatic send_random(int n);
		repeat (n) send_sample(random_splat());
	endtask

	// axes still zero after reset: every splat misses
	task automatic test_reset_film;
		send_sample(make_splat(16'h1234, 16'h8000, Q_ONE, 16'hFFFF, 16'h0, 16'h7FFF));
		send_sample(make_splat(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		drain_film();
	endtask

	task automatic test_directed_splats;
		sample_word_t c;
		set_film({Q_ONE, 32'h0}, {32'h0, Q_ONE}, {16'h0, Q_ONE, 16'h0}, 512, 512);
		send_sample(make_splat(16'h0, 16'h0, Q_ONE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_sample(make_splat(16'h0, 16'h0, Q_ONE, 16'h0, 16'h0, 16'h0));
		send_sample(make_splat(16'h0, 16'h0, Q_ONE, 16'h1001, 16'h8000, 16'h0003));
		// film corners
		send_sample(make_splat(-16'sd16384, -16'sd16384, Q_ONE, 16'h1, 16'h2, 16'h3));
		send_sample(make_splat(16'd16383, 16'd16383, Q_ONE, 16'hFFFF, 16'h0, 16'hFFFF));
		// just past the right edge, just past the left one
		send_sample(make_splat(16'd16384, 16'h0, Q_ONE, 16'h5, 16'h5, 16'h5));
		send_sample(make_splat(-16'sd16385, 16'h0, Q_ONE, 16'h5, 16'h5, 16'h5));
		// ray at right angles to the view: zero denominator
		send_sample(make_splat(16'h4000, 16'h0, 16'h0, 16'h5, 16'h5, 16'h5));
		// backward ray, negative denominator
		send_sample(make_splat(16'h0, 16'h0, 16'hC000, 16'h9, 16'h9, 16'h9));
		send_sample(make_splat(16'h7FFF, 16'h8000, 16'h8000, 16'h9, 16'h9, 16'h9));
		c.kind = KIND_CLEAR;
		c.red = 16'hABCD; c.green = 16'h0; c.blue = 16'hFFFF;
		c.ray_x = 16'hFFFF; c.ray_y = 16'hFFFF; c.ray_z = 16'hFFFF;
		send_sample(c);
		send_sample(make_splat(16'h0, 16'h0, Q_ONE, 16'h0, 16'hFFFF, 16'h1234));
		send_sample(make_splat(16'h0, 16'h0, Q_ONE, 16'hFFFF, 16'hFFFF, 16'h0));
		send_sample(make_splat(16'h100, 16'h100, Q_ONE, 16'h0, 16'h0, 16'h0));
		drain_film();
	endtask

	// tiny film so pixels collect many samples
	task automatic test_small_film;
		set_film({Q_ONE, 32'h0}, {32'h0, Q_ONE}, {16'h0, Q_ONE, 16'h0}, 4, 3);
		send_random(250);
		drain_film();
		set_film({Q_ONE, 32'h0}, {32'h0, Q_ONE}, {16'h0, Q_ONE, 16'h0}, 1, 1);
		send_random(150);
		drain_film();
	endtask

	task automatic test_random_axes;
		set_film(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
			48'({$urandom, $urandom}),
			10'($urandom_range(1, 512)), 10'($urandom_range(1, 512)));
		send_random(150);
		drain_film();
		// scaled camera with skewed axes
		set_film({16'h2000, 16'h0100, 16'hFF00}, {16'h0200, 16'h0100, 16'h2000},
			{16'hFE00, 16'h3000, 16'h0200}, 512, 1);
		send_random(150);
		drain_film();
		// zero height: everything misses; stray register index is ignored
		set_film({Q_ONE, 32'h0}, {32'h0, Q_ONE}, {16'h0, Q_ONE, 16'h0}, 7, 0);
		write_reg(3'd5, 48'hFFFF_FFFF_FFFF);
		write_reg(3'd7, 48'h0);
		send_random(40);
		drain_film();
	endtask

	task automatic test_backpressure;
		set_film({Q_ONE, 32'h0}, {32'h0, Q_ONE}, {16'h0, Q_ONE, 16'h0}, 16, 16);
		@(negedge clk);
		hold_cycles = 800;
		send_random(12);
		drain_film();
	endtask

	task automatic test_full_film;
		set_film({Q_ONE, 32'h0}, {32'h0, Q_ONE}, {16'h0, Q_ONE, 16'h0}, 512, 512);
		calm = 1'b1;
		send_random(400);
		calm = 1'b0;
		send_random(400);
		drain_film();
	endtask

	initial begin
		view_axis_q = '0;
		film_x_q    = '0;
		film_y_q    = '0;
		width_q     = 10'd512;
		height_q    = 10'd512;
		fill_colour = '0;
		fail_count  = 0;
		idle_cycles = 0;
		calm        = 1'b0;
		hold_cycles = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_film();
		test_directed_splats();
		test_small_film();
		test_random_axes();
		test_backpressure();
		test_full_film();
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
